>>> rtl/core/fcc_lattice_gas_tick_unit_macros.svh
// Assertion helpers for the lattice gas tick unit.
`ifndef FCC_LATTICE_GAS_TICK_UNIT_MACROS_SVH
`define FCC_LATTICE_GAS_TICK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FCC_ASSERT_SAME(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FCC_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/fcc_pkg.sv
`default_nettype none
package fcc_pkg;

   localparam int unsigned VALUE_W = 13;
   localparam int unsigned MOVE_W  = 12;
   localparam int unsigned DIR_W   = 4;
   localparam int unsigned TICK_W  = 16;
   localparam logic [DIR_W-1:0] LAST_DIR = 4'd11;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_UNKNOWN = 2'd3
   } cmd_type;

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_COLLIDE = 6'b000100,
      ST_CDRAIN  = 6'b001000,
      ST_STREAM  = 6'b010000,
      ST_SDRAIN  = 6'b100000
   } state_type;

   // Step codes: zero, plus one, minus one.
   localparam logic [1:0] STEP_Z = 2'b00;
   localparam logic [1:0] STEP_P = 2'b01;
   localparam logic [1:0] STEP_M = 2'b11;

   localparam logic [1:0] STEP_X [12] = '{STEP_P, STEP_M, STEP_P, STEP_M, STEP_P, STEP_M,
                                         STEP_P, STEP_M, STEP_Z, STEP_Z, STEP_Z, STEP_Z};
   localparam logic [1:0] STEP_Y [12] = '{STEP_P, STEP_M, STEP_M, STEP_P, STEP_Z, STEP_Z,
                                         STEP_Z, STEP_Z, STEP_P, STEP_M, STEP_P, STEP_M};
   localparam logic [1:0] STEP_DZ [12] = '{STEP_Z, STEP_Z, STEP_Z, STEP_Z, STEP_P, STEP_M,
                                          STEP_M, STEP_P, STEP_P, STEP_M, STEP_M, STEP_P};

   localparam logic [MOVE_W-1:0] PAIR_01 = 12'h003;
   localparam logic [MOVE_W-1:0] PAIR_23 = 12'h00C;
   localparam logic [MOVE_W-1:0] PAIR_45 = 12'h030;
   localparam logic [MOVE_W-1:0] PAIR_67 = 12'h0C0;
   localparam logic [MOVE_W-1:0] PAIR_89 = 12'h300;
   localparam logic [MOVE_W-1:0] PAIR_AB = 12'hC00;

   typedef struct packed {
      logic [VALUE_W-1:0] node;
      logic [MOVE_W-1:0]  out;
   } collide_type;

   // Massless, three movers: merge to mass; else rotate first head-on pair.
   function automatic collide_type collide(input logic [VALUE_W-1:0] v);
      collide_type         r;
      logic [MOVE_W-1:0]   mv;
      logic [3:0]          cnt;
      mv  = v[MOVE_W-1:0];
      cnt = '0;
      for (int i = 0; i < MOVE_W; i++) begin
         cnt = cnt + 4'(mv[i]);
      end
      if (!v[MOVE_W] && cnt == 4'd3) begin
         r.node = {1'b1, {MOVE_W{1'b0}}};
         r.out  = '0;
      end else begin
         priority if ((mv & PAIR_01) == PAIR_01 && (mv & PAIR_45) == '0) begin
            mv = mv ^ (PAIR_01 | PAIR_45);
         end else if ((mv & PAIR_45) == PAIR_45 && (mv & PAIR_67) == '0) begin
            mv = mv ^ (PAIR_45 | PAIR_67);
         end else if ((mv & PAIR_67) == PAIR_67 && (mv & PAIR_89) == '0) begin
            mv = mv ^ (PAIR_67 | PAIR_89);
         end else if ((mv & PAIR_89) == PAIR_89 && (mv & PAIR_AB) == '0) begin
            mv = mv ^ (PAIR_89 | PAIR_AB);
         end else if ((mv & PAIR_AB) == PAIR_AB && (mv & PAIR_23) == '0) begin
            mv = mv ^ (PAIR_AB | PAIR_23);
         end else if ((mv & PAIR_23) == PAIR_23 && (mv & PAIR_01) == '0) begin
            mv = mv ^ (PAIR_23 | PAIR_01);
         end else begin
            mv = mv;
         end
         r.node = {v[MOVE_W], {MOVE_W{1'b0}}};
         r.out  = mv;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/fcc_lattice_gas_tick_unit.sv
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+-----------------------------
// request   | req_command, req_node_index, req_node_value  | start high while busy low
// response  | rsp_read_value, rsp_tick_count               | rsp_valid, one cycle strobe
//
// Write, read and unknown commands answer in the next cycle; the next command is
// taken right away. A tick sweeps the node memory once for collision and then
// gathers twelve neighbors per node from the outgoing memory, one read a cycle.
// After reset a clearing pass zeroes the node memory with busy high.
// The receiver cannot stall; each result strobe is taken in its cycle.
`default_nettype none
`include "fcc_lattice_gas_tick_unit_macros.svh"
module fcc_lattice_gas_tick_unit #(
   parameter int unsigned X_BITS = 4,
   parameter int unsigned Y_BITS = 3,
   parameter int unsigned Z_BITS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [9:0]  req_node_index,
   input  wire logic [12:0] req_node_value,
   output logic             rsp_valid,
   output logic [12:0]      rsp_read_value,
   output logic [15:0]      rsp_tick_count
);

   localparam int unsigned NB    = X_BITS + Y_BITS + Z_BITS;
   localparam int unsigned NODES = 1 << NB;
   localparam int unsigned VW    = fcc_pkg::VALUE_W;
   localparam int unsigned MW    = fcc_pkg::MOVE_W;
   localparam int unsigned DW    = fcc_pkg::DIR_W;
   localparam int unsigned TW    = fcc_pkg::TICK_W;

   // Add the step codes of a direction to each coordinate with wrap.
   function automatic logic [NB-1:0] neighbor(input logic [NB-1:0] idx,
                                              input logic [DW-1:0] d);
      logic [X_BITS-1:0] x;
      logic [Y_BITS-1:0] y;
      logic [Z_BITS-1:0] z;
      logic [1:0]        sx;
      logic [1:0]        sy;
      logic [1:0]        sz;
      x  = idx[X_BITS-1:0];
      y  = idx[X_BITS+Y_BITS-1:X_BITS];
      z  = idx[NB-1:X_BITS+Y_BITS];
      sx = fcc_pkg::STEP_X[d];
      sy = fcc_pkg::STEP_Y[d];
      sz = fcc_pkg::STEP_DZ[d];
      x  = x + ((sx == fcc_pkg::STEP_P) ? X_BITS'(1) :
                (sx == fcc_pkg::STEP_M) ? {X_BITS{1'b1}} : X_BITS'(0));
      y  = y + ((sy == fcc_pkg::STEP_P) ? Y_BITS'(1) :
                (sy == fcc_pkg::STEP_M) ? {Y_BITS{1'b1}} : Y_BITS'(0));
      z  = z + ((sz == fcc_pkg::STEP_P) ? Z_BITS'(1) :
                (sz == fcc_pkg::STEP_M) ? {Z_BITS{1'b1}} : Z_BITS'(0));
      return {z, y, x};
   endfunction

   fcc_pkg::state_type state_ff, state_in;
   logic [NB-1:0]      cnt_ff, cnt_in;
   logic [DW-1:0]      dir_ff, dir_in;
   logic               pv_ff, pv_in;
   logic [NB-1:0]      pa_ff;
   logic [DW-1:0]      pd_ff;
   logic               mass_ff, mass_in;
   logic [MW-1:0]      inc_ff, inc_in;
   logic [TW-1:0]      tick_ff, tick_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_rd_ff, rsp_rd_in;

   logic [VW-1:0]      node_mem [NODES];
   logic [MW-1:0]      out_mem [NODES];
   logic [VW-1:0]      node_q_ff;
   logic [MW-1:0]      out_q_ff;

   logic               nwe;
   logic [NB-1:0]      nwa, nra;
   logic [VW-1:0]      nwd;
   logic               owe;
   logic [MW-1:0]      owd;
   logic [NB-1:0]      ora;
   logic               accept;
   logic [NB-1:0]      req_addr;
   fcc_pkg::collide_type col;
   logic [MW-1:0]      gathered;

   assign busy           = (state_ff != fcc_pkg::ST_IDLE);
   assign accept         = start && !busy;
   assign req_addr       = NB'(req_node_index);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff ? node_q_ff : '0;
   assign rsp_tick_count = tick_ff;
   assign col            = fcc_pkg::collide(node_q_ff);
   assign gathered       = ((pd_ff == '0) ? '0 : inc_ff) |
                           (out_q_ff[pd_ff] ? (MW'(1) << pd_ff) : '0);

   // Sequence the clear, collide and stream sweeps, and serve commands while idle.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dir_in       = dir_ff;
      pv_in        = 1'b0;
      mass_in      = mass_ff;
      inc_in       = inc_ff;
      tick_in      = tick_ff;
      rsp_valid_in = 1'b0;
      rsp_rd_in    = 1'b0;
      nwe          = 1'b0;
      nwa          = pa_ff;
      nwd          = '0;
      nra          = cnt_ff;
      owe          = 1'b0;
      owd          = col.out;
      ora          = neighbor(cnt_ff, dir_ff ^ DW'(1));
      unique case (state_ff)
         fcc_pkg::ST_CLEAR: begin
            nwe    = 1'b1;
            nwa    = cnt_ff;
            cnt_in = cnt_ff + NB'(1);
            if (cnt_ff == '1) begin
               state_in = fcc_pkg::ST_IDLE;
            end
         end
         fcc_pkg::ST_IDLE: begin
            nra = req_addr;
            nwa = req_addr;
            nwd = req_node_value;
            if (accept) begin
               unique case (fcc_pkg::cmd_type'(req_command))
                  fcc_pkg::CMD_WRITE: begin
                     nwe          = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  fcc_pkg::CMD_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_rd_in    = 1'b1;
                  end
                  fcc_pkg::CMD_TICK: begin
                     cnt_in   = '0;
                     state_in = fcc_pkg::ST_COLLIDE;
                  end
                  fcc_pkg::CMD_UNKNOWN: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         fcc_pkg::ST_COLLIDE, fcc_pkg::ST_CDRAIN: begin
            // Write back the node read in the previous cycle.
            nwe = pv_ff;
            owe = pv_ff;
            nwd = col.node;
            if (state_ff == fcc_pkg::ST_COLLIDE) begin
               pv_in  = 1'b1;
               cnt_in = cnt_ff + NB'(1);
               if (cnt_ff == '1) begin
                  state_in = fcc_pkg::ST_CDRAIN;
               end
            end else begin
               cnt_in   = '0;
               dir_in   = '0;
               state_in = fcc_pkg::ST_STREAM;
            end
         end
         fcc_pkg::ST_STREAM, fcc_pkg::ST_SDRAIN: begin
            // Gather one direction bit a cycle; write the node after the last.
            if (pv_ff) begin
               inc_in = gathered;
               if (pd_ff == '0) begin
                  mass_in = node_q_ff[MW];
               end
            end
            nwe = pv_ff && (pd_ff == fcc_pkg::LAST_DIR);
            nwd = {((pd_ff == '0) ? node_q_ff[MW] : mass_ff), gathered};
            if (state_ff == fcc_pkg::ST_STREAM) begin
               pv_in = 1'b1;
               if (dir_ff == fcc_pkg::LAST_DIR) begin
                  dir_in = '0;
                  cnt_in = cnt_ff + NB'(1);
                  if (cnt_ff == '1) begin
                     state_in = fcc_pkg::ST_SDRAIN;
                  end
               end else begin
                  dir_in = dir_ff + DW'(1);
               end
            end else begin
               tick_in      = tick_ff + TW'(1);
               rsp_valid_in = 1'b1;
               state_in     = fcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcc_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcc_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         dir_ff       <= '0;
         pv_ff        <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_rd_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dir_ff       <= dir_in;
         pv_ff        <= pv_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_rd_ff    <= rsp_rd_in;
      end
   end

   // Track the address and direction of the read in flight, and hold the gathered mass and bits.
   always_ff @(posedge clock) begin
      pa_ff   <= cnt_ff;
      pd_ff   <= dir_ff;
      mass_ff <= mass_in;
      inc_ff  <= inc_in;
   end

   // Node memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (nwe) begin
         node_mem[nwa] <= nwd;
      end
      node_q_ff <= node_mem[nra];
   end

   // Outgoing memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (owe) begin
         out_mem[pa_ff] <= owd;
      end
      out_q_ff <= out_mem[ora];
   end

   `FCC_ASSERT_NEXT(a_tick_done, clock, reset, state_ff == fcc_pkg::ST_SDRAIN, rsp_valid_ff && tick_ff == $past(tick_ff) + TW'(1), "tick end without strobe or count step")
   `FCC_ASSERT_NEXT(a_cmd_answer, clock, reset, accept && req_command != fcc_pkg::CMD_TICK, rsp_valid_ff && tick_ff == $past(tick_ff), "command not answered next cycle")
   `FCC_ASSERT_SAME(a_dir_range, clock, reset, state_ff == fcc_pkg::ST_STREAM, dir_ff <= fcc_pkg::LAST_DIR, "direction counter out of range")
   `FCC_ASSERT_SAME(a_no_strobe_busy, clock, reset, rsp_valid_ff, !busy, "strobe while sweeping")

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;

   localparam int NODES = 1024;
   localparam int XB = 4;
   localparam int YB = 3;
   localparam int ZB = 3;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int MAX_RANDOM_TICKS = 12;

   typedef struct {
      fcc_pkg::cmd_type cmd;
      logic [9:0]       idx;
      logic [12:0]      val;
      bit               drain;
   } lattice_cmd_type;

   typedef struct {
      logic [12:0] read_value;
      logic [15:0] tick_count;
   } lattice_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0]  req_command = '0;
   logic [9:0]  req_node_index = '0;
   logic [12:0] req_node_value = '0;
   logic busy;
   logic rsp_valid;
   logic [12:0] rsp_read_value;
   logic [15:0] rsp_tick_count;

   fcc_lattice_gas_tick_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_node_index(req_node_index),
      .req_node_value(req_node_value), .rsp_valid(rsp_valid),
      .rsp_read_value(rsp_read_value), .rsp_tick_count(rsp_tick_count)
   );

   lattice_cmd_type    pending_cmds[$];
   lattice_answer_type expected_answers[$];
   logic [12:0]   lattice_mem [NODES];
   logic [11:0]   leaving_mem [NODES];
   logic [15:0]   ticks_done;
   int            issued_count = 0;
   int            accepted_count = 0;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            gap_left = 0;
   bit            gapless = 1'b0;
   logic [9:0]    written_nodes[$];
   int            random_ticks = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Step offsets per direction.
   function automatic int step_of(input int axis, input int dir);
      int sx[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
      int sy[12] = '{1, -1, -1, 1, 0, 0, 0, 0, 1, -1, 1, -1};
      int sz[12] = '{0, 0, 0, 0, 1, -1, -1, 1, 1, -1, -1, 1};
      if (axis == 0) begin
         return sx[dir];
      end else if (axis == 1) begin
         return sy[dir];
      end
      return sz[dir];
   endfunction

   function automatic int neighbor_node(input int n, input int dir);
      int x;
      int y;
      int z;
      x = (n + step_of(0, dir)) & ((1 << XB) - 1);
      y = ((n >> XB) + step_of(1, dir)) & ((1 << YB) - 1);
      z = ((n >> (XB + YB)) + step_of(2, dir)) & ((1 << ZB) - 1);
      return x | (y << XB) | (z << (XB + YB));
   endfunction

   // Collide every node, then stream particles to neighbors.
   task automatic advance_lattice();
      logic [11:0] mv;
      logic [11:0] incoming;
      int          src;
      for (int n = 0; n < NODES; n++) begin
         mv = lattice_mem[n][11:0];
         if (!lattice_mem[n][12] && $countones(mv) == 3) begin
            lattice_mem[n] = 13'h1000;
            leaving_mem[n] = '0;
         end else begin
            if ((mv & 12'h003) == 12'h003 && (mv & 12'h030) == 0) mv ^= 12'h033;
            else if ((mv & 12'h030) == 12'h030 && (mv & 12'h0C0) == 0) mv ^= 12'h0F0;
            else if ((mv & 12'h0C0) == 12'h0C0 && (mv & 12'h300) == 0) mv ^= 12'h3C0;
            else if ((mv & 12'h300) == 12'h300 && (mv & 12'hC00) == 0) mv ^= 12'hF00;
            else if ((mv & 12'hC00) == 12'hC00 && (mv & 12'h00C) == 0) mv ^= 12'hC0C;
            else if ((mv & 12'h00C) == 12'h00C && (mv & 12'h003) == 0) mv ^= 12'h00F;
            lattice_mem[n] = {lattice_mem[n][12], 12'h000};
            leaving_mem[n] = mv;
         end
      end
      for (int n = 0; n < NODES; n++) begin
         incoming = '0;
         for (int i = 0; i < 12; i++) begin
            src = neighbor_node(n, i ^ 1);
            incoming[i] = leaving_mem[src][i];
         end
         lattice_mem[n] = {lattice_mem[n][12], incoming};
      end
      ticks_done = ticks_done + 16'd1;
   endtask

   task automatic predict_answer(input lattice_cmd_type c);
      lattice_answer_type a;
      a.read_value = '0;
      case (c.cmd)
         fcc_pkg::CMD_WRITE: lattice_mem[c.idx] = c.val;
         fcc_pkg::CMD_READ:  a.read_value = lattice_mem[c.idx];
         fcc_pkg::CMD_TICK:  advance_lattice();
         default: ;
      endcase
      a.tick_count = ticks_done;
      expected_answers.push_back(a);
   endtask

   // Check results, then record accepted transactions and the timeout.
   always @(posedge clock) begin
      lattice_answer_type e;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected result: read_value %0h tick_count %0d",
                      rsp_read_value, rsp_tick_count);
               mismatch_count++;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_read_value !== e.read_value) begin
                  $error("read_value expected %0h actual %0h", e.read_value, rsp_read_value);
                  mismatch_count++;
               end
               if (rsp_tick_count !== e.tick_count) begin
                  $error("tick_count expected %0d actual %0d", e.tick_count, rsp_tick_count);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_answer('{fcc_pkg::cmd_type'(req_command), req_node_index,
                             req_node_value, 1'b0});
            accepted_count++;
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Drive the next transaction after its gap; hold until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (issued_count != accepted_count) begin
            // hold
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && expected_answers.size() > 0)) begin
            req_command <= pending_cmds[0].cmd;
            req_node_index <= pending_cmds[0].idx;
            req_node_value <= pending_cmds[0].val;
            void'(pending_cmds.pop_front());
            start <= 1'b1;
            issued_count <= issued_count + 1;
            if ($urandom_range(0, 9) == 0) gapless = ~gapless;
            gap_left <= gapless ? 0 : $urandom_range(0, 18);
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic logic [12:0] random_node_value();
      logic [12:0] v;
      logic [11:0] pairs[6] = '{12'h003, 12'h030, 12'h0C0, 12'h300, 12'hC00, 12'h00C};
      case ($urandom_range(0, 3))
         0: v = 13'($urandom);
         1: v = {1'($urandom), pairs[$urandom_range(0, 5)] |
                 (12'($urandom) & 12'($urandom) & 12'($urandom))};
         2: v = 13'((1 << $urandom_range(0, 11)) | (1 << $urandom_range(0, 11)) |
                    (1 << $urandom_range(0, 11)));
         default: v = {1'($urandom), pairs[$urandom_range(0, 5)]};
      endcase
      return v;
   endfunction

   task automatic queue_cmd(input fcc_pkg::cmd_type c, input logic [9:0] i,
                            input logic [12:0] v, input bit d = 1'b0);
      pending_cmds.push_back('{c, i, v, d});
      if (c == fcc_pkg::CMD_WRITE) written_nodes.push_back(i);
   endtask

   initial begin
      int n;
      for (int k = 0; k < NODES; k++) begin
         lattice_mem[k] = '0;
         leaving_mem[k] = '0;
      end
      ticks_done = '0;

      // Directed: empty tick, every pair rotation, merge, blocked pairs, extremes.
      queue_cmd(fcc_pkg::CMD_TICK, 10'h3FF, 13'h1FFF);
      queue_cmd(fcc_pkg::CMD_READ, 10'd0, 13'd0);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd0, 13'h0003);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd1023, 13'h1FFF);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd100, 13'h0030);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd200, 13'h00C0);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd300, 13'h0300);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd400, 13'h0C00);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd500, 13'h000C);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd600, 13'h0111);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd700, 13'h1111);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd800, 13'h0033);
      queue_cmd(fcc_pkg::CMD_WRITE, 10'd900, 13'h1000);
      queue_cmd(fcc_pkg::CMD_READ, 10'd1023, 13'h1FFF);
      queue_cmd(fcc_pkg::CMD_UNKNOWN, 10'h3FF, 13'h1FFF);
      queue_cmd(fcc_pkg::CMD_TICK, 10'd0, 13'd0, 1'b1);
      queue_cmd(fcc_pkg::CMD_READ, 10'd600, 13'd0);
      queue_cmd(fcc_pkg::CMD_READ, 10'd900, 13'd0);
      queue_cmd(fcc_pkg::CMD_READ, 10'd1023, 13'd0);
      queue_cmd(fcc_pkg::CMD_READ, 10'(neighbor_node(0, 4)), 13'd0);
      queue_cmd(fcc_pkg::CMD_READ, 10'(neighbor_node(0, 5)), 13'd0);
      queue_cmd(fcc_pkg::CMD_UNKNOWN, 10'd0, 13'd0);

      // Random: writes, ticks, reads and unknown commands interleaved; reads mostly near written nodes.
      for (int k = 0; k < 100; k++) begin
         n = $urandom_range(0, 11);
         if (n == 0 && random_ticks < MAX_RANDOM_TICKS) begin
            queue_cmd(fcc_pkg::CMD_TICK, 10'($urandom), 13'($urandom),
                      $urandom_range(0, 3) == 0);
            random_ticks++;
         end else if (n < 6) begin
            if (written_nodes.size() > 0 && $urandom_range(0, 1))
               queue_cmd(fcc_pkg::CMD_WRITE,
                         10'(neighbor_node(written_nodes[$urandom_range(0,
                             written_nodes.size() - 1)], $urandom_range(0, 11))),
                         random_node_value());
            else
               queue_cmd(fcc_pkg::CMD_WRITE, 10'($urandom), random_node_value());
         end else if (n < 11) begin
            if (written_nodes.size() > 0 && $urandom_range(0, 3) != 0)
               queue_cmd(fcc_pkg::CMD_READ,
                         10'(neighbor_node(written_nodes[$urandom_range(0,
                             written_nodes.size() - 1)], $urandom_range(0, 11))),
                         13'($urandom));
            else
               queue_cmd(fcc_pkg::CMD_READ, 10'($urandom), 13'($urandom));
         end else begin
            queue_cmd(fcc_pkg::CMD_UNKNOWN, 10'($urandom), 13'($urandom));
         end
      end

      // Release reset at a falling edge.
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Drain, then allow a short settle before the verdict.
      wait (pending_cmds.size() == 0 && issued_count == accepted_count &&
            expected_answers.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/fcc_pkg.sv
rtl/core/fcc_lattice_gas_tick_unit.sv
tb/testbench.sv
